// File: sv/bpnhm_pkg.sv
// ----------------------------------------------------------------------------
// bpnhm_pkg
// Shared codes and types of the bus poll node health monitor.
// ----------------------------------------------------------------------------
package bpnhm_pkg;

  // bus event codes carried by func
  typedef enum logic [2:0] {
    FUNC_FRAME   = 3'd0,
    FUNC_SILENCE = 3'd1,
    FUNC_REPLY   = 3'd2,
    FUNC_DATA    = 3'd3,
    FUNC_SESSION = 3'd4,
    FUNC_LOAD    = 3'd5
  } func_e;

  // frame kinds on the result side
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_POLL  = 2'd1,
    KIND_BCAST = 2'd2
  } kind_e;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_FRAME_RD = 6'b000010,
    ST_SCAN     = 6'b000100,
    ST_CNT_RD   = 6'b001000,
    ST_CNT_MOD  = 6'b010000,
    ST_DONE     = 6'b100000
  } state_e;

  // register map: index of a register is paddr[2]
  localparam logic CFG_IDX_FAULT_LIMIT = 1'b0;

  localparam logic [7:0] FAULT_LIMIT_RESET = 8'd10;
  localparam logic [7:0] FAULT_LIMIT_MAX   = 8'hFF;
  localparam logic [7:0] FAULT_LIMIT_CAP   = 8'd254;

endpackage

// File: sv/bpnhm_ram.sv
// ----------------------------------------------------------------------------
// bpnhm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpnhm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/bus_poll_node_health_monitor.sv
// ----------------------------------------------------------------------------
// bus_poll_node_health_monitor
// Round-robin bus poll master that tracks the health of each polled node.
// ----------------------------------------------------------------------------
// Usage: bus events enter on the valid/ready input channel (func plus reply
// and table-load fields), one transfer at a time. Each event yields exactly
// one result transfer on the output channel: the frame to send (none, poll
// or broadcast), the polled address and slot, and the healthy-node mask.
// fault_limit is written over the APB-style port, and the user must write
// it only while the block is idle; the block itself does not enforce this.
// The sequencer goes from idle to done for most events, through a read of
// the address table RAM for a poll, through a count read and update for
// silence charged to a node, and through a scan of the address table RAM at
// one entry per cycle for a status reply. One event is worked at a time; the
// next is taken once the sequencer is back in idle.
// The result sits in an output register, so the next event is taken while
// a result waits; a stalled receiver only holds back the following result.
// Reset clears the mask, all fault counts (per-node valid bits) and pending
// data, and puts the slot counter and the last polled node on the broadcast
// slot; the address table is undefined until loaded.
// ----------------------------------------------------------------------------
module bus_poll_node_health_monitor #(
  parameter int unsigned NODE_COUNT = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // event input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  func_i,
  input  logic [7:0]  reply_fault_i,
  input  logic [7:0]  reply_address_i,
  input  logic [3:0]  entry_index_i,
  input  logic [7:0]  entry_address_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  frame_kind_o,
  output logic [7:0]  poll_address_o,
  output logic [3:0]  poll_index_o,
  output logic [15:0] node_ok_mask_o
);

  localparam int unsigned NAW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int unsigned CW  = $clog2(NODE_COUNT + 1);
  localparam logic [4:0]     NODES5   = 5'(NODE_COUNT);
  localparam logic [CW-1:0]  NODES_CW = CW'(NODE_COUNT);
  localparam logic [NAW-1:0] LAST_IDX = NAW'(NODE_COUNT - 1);

  // control state
  bpnhm_pkg::state_e     state_q, state_d;
  logic [7:0]            fault_limit_q;
  logic [4:0]            slot_q, slot_d;
  logic                  pend_q, pend_d;
  logic [4:0]            last_q, last_d;
  logic [15:0]           mask_q, mask_d;
  logic [NODE_COUNT-1:0] cnt_vld_q, cnt_vld_d;
  logic [CW-1:0]         scan_cnt_q, scan_cnt_d;
  logic                  rd_vld_q, rd_vld_d;
  logic                  found_q, found_d;
  logic                  out_valid_q, out_valid_d;

  // payload registers
  logic [NAW-1:0]        rd_idx_q, rd_idx_d;
  logic [NAW-1:0]        found_idx_q, found_idx_d;
  logic [NAW-1:0]        tgt_q, tgt_d;
  logic [7:0]            rfault_q, rfault_d;
  logic [7:0]            raddr_q, raddr_d;
  bpnhm_pkg::kind_e      res_kind_q, res_kind_d;
  logic [7:0]            res_paddr_q, res_paddr_d;
  logic [3:0]            res_pidx_q, res_pidx_d;
  bpnhm_pkg::kind_e      out_kind_q;
  logic [7:0]            out_paddr_q;
  logic [3:0]            out_pidx_q;
  logic [15:0]           out_mask_q;
  logic                  load_out;

  // memory ports
  logic                  tbl_we;
  logic [NAW-1:0]        tbl_raddr;
  logic [7:0]            tbl_rdata;
  logic                  cnt_we;
  logic [7:0]            cnt_wdata;
  logic [7:0]            cnt_rdata;

  // helpers
  logic                  in_fire;
  logic                  cfg_wr;
  logic [4:0]            sc;
  logic                  bcast;
  logic                  hit;
  logic [NAW-1:0]        hit_idx;
  logic [7:0]            lim;
  logic [7:0]            cur;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == bpnhm_pkg::CFG_IDX_FAULT_LIMIT);
  assign prdata = (paddr[2] == bpnhm_pkg::CFG_IDX_FAULT_LIMIT) ? {24'h0, fault_limit_q}
                                                               : 32'h0;

  // handshakes
  assign in_ready_o  = (state_q == bpnhm_pkg::ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // slot selection for a frame request
  assign sc    = (slot_q > NODES5) ? 5'd0 : slot_q;
  assign bcast = pend_q || (sc == NODES5);

  // table scan compare, last match wins
  assign hit     = (tbl_rdata == raddr_q);
  assign hit_idx = hit ? rd_idx_q : found_idx_q;

  // fault count read-modify-write
  assign lim       = (fault_limit_q == bpnhm_pkg::FAULT_LIMIT_MAX) ? bpnhm_pkg::FAULT_LIMIT_CAP
                                                                   : fault_limit_q;
  assign cur       = cnt_vld_q[tgt_q] ? cnt_rdata : 8'd0;
  assign cnt_wdata = cur + 8'd1;

  // address table
  bpnhm_ram #(
    .WIDTH (8),
    .DEPTH (NODE_COUNT)
  ) u_tbl_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (entry_index_i[NAW-1:0]),
    .wdata_i (entry_address_i),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // fault counters
  bpnhm_ram #(
    .WIDTH (8),
    .DEPTH (NODE_COUNT)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (tgt_q),
    .wdata_i (cnt_wdata),
    .raddr_i (tgt_q),
    .rdata_o (cnt_rdata)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    pend_d      = pend_q;
    last_d      = last_q;
    mask_d      = mask_q;
    cnt_vld_d   = cnt_vld_q;
    scan_cnt_d  = scan_cnt_q;
    rd_vld_d    = 1'b0;
    found_d     = found_q;
    out_valid_d = out_valid_q;
    rd_idx_d    = scan_cnt_q[NAW-1:0];
    found_idx_d = found_idx_q;
    tgt_d       = tgt_q;
    rfault_d    = rfault_q;
    raddr_d     = raddr_q;
    res_kind_d  = res_kind_q;
    res_paddr_d = res_paddr_q;
    res_pidx_d  = res_pidx_q;
    tbl_we      = 1'b0;
    tbl_raddr   = sc[NAW-1:0];
    cnt_we      = 1'b0;
    load_out    = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      bpnhm_pkg::ST_IDLE: begin
        if (in_fire) begin
          res_kind_d  = bpnhm_pkg::KIND_NONE;
          res_paddr_d = 8'd0;
          res_pidx_d  = 4'd0;
          rfault_d    = reply_fault_i;
          raddr_d     = reply_address_i;
          state_d     = bpnhm_pkg::ST_DONE;
          case (bpnhm_pkg::func_e'(func_i))
            bpnhm_pkg::FUNC_FRAME: begin
              slot_d = sc + 5'd1;
              if (bcast) begin
                pend_d     = 1'b0;
                res_kind_d = bpnhm_pkg::KIND_BCAST;
                last_d     = NODES5;
              end else begin
                res_kind_d = bpnhm_pkg::KIND_POLL;
                res_pidx_d = sc[3:0];
                last_d     = sc;
                state_d    = bpnhm_pkg::ST_FRAME_RD;
              end
            end
            bpnhm_pkg::FUNC_SILENCE: begin
              if (last_q < NODES5) begin
                tgt_d   = last_q[NAW-1:0];
                state_d = bpnhm_pkg::ST_CNT_RD;
              end
            end
            bpnhm_pkg::FUNC_REPLY: begin
              scan_cnt_d = '0;
              found_d    = 1'b0;
              state_d    = bpnhm_pkg::ST_SCAN;
            end
            bpnhm_pkg::FUNC_DATA: begin
              pend_d = 1'b1;
            end
            bpnhm_pkg::FUNC_SESSION: begin
              mask_d    = 16'd0;
              cnt_vld_d = '0;
            end
            bpnhm_pkg::FUNC_LOAD: begin
              tbl_we = ({1'b0, entry_index_i} < NODES5);
            end
            default: ;
          endcase
        end
      end

      bpnhm_pkg::ST_FRAME_RD: begin
        res_paddr_d = tbl_rdata;
        state_d     = bpnhm_pkg::ST_DONE;
      end

      bpnhm_pkg::ST_SCAN: begin
        tbl_raddr = scan_cnt_q[NAW-1:0];
        if (scan_cnt_q < NODES_CW) begin
          rd_vld_d   = 1'b1;
          scan_cnt_d = scan_cnt_q + CW'(1);
        end
        if (rd_vld_q && hit) begin
          found_d     = 1'b1;
          found_idx_d = rd_idx_q;
        end
        // last entry compared: act on the winning slot
        if (rd_vld_q && (rd_idx_q == LAST_IDX)) begin
          if (hit || found_q) begin
            if (rfault_q == 8'd0) begin
              mask_d             = mask_q | (16'd1 << hit_idx);
              cnt_vld_d[hit_idx] = 1'b0;
              state_d            = bpnhm_pkg::ST_DONE;
            end else begin
              tgt_d   = hit_idx;
              state_d = bpnhm_pkg::ST_CNT_RD;
            end
          end else begin
            state_d = bpnhm_pkg::ST_DONE;
          end
        end
      end

      bpnhm_pkg::ST_CNT_RD: begin
        state_d = bpnhm_pkg::ST_CNT_MOD;
      end

      bpnhm_pkg::ST_CNT_MOD: begin
        // count up below the limit; at the limit the node drops out
        if (cur < lim) begin
          cnt_we = 1'b1;
        end else if (cur == lim) begin
          cnt_we = 1'b1;
          mask_d = mask_q & ~(16'd1 << tgt_q);
        end
        if (cnt_we) begin
          cnt_vld_d[tgt_q] = 1'b1;
        end
        state_d = bpnhm_pkg::ST_DONE;
      end

      bpnhm_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          load_out    = 1'b1;
          state_d     = bpnhm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = bpnhm_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= bpnhm_pkg::ST_IDLE;
      fault_limit_q <= bpnhm_pkg::FAULT_LIMIT_RESET;
      slot_q        <= NODES5;
      pend_q        <= 1'b0;
      last_q        <= NODES5;
      mask_q        <= 16'd0;
      cnt_vld_q     <= '0;
      scan_cnt_q    <= '0;
      rd_vld_q      <= 1'b0;
      found_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_wr) begin
        fault_limit_q <= pwdata[7:0];
      end
      slot_q      <= slot_d;
      pend_q      <= pend_d;
      last_q      <= last_d;
      mask_q      <= mask_d;
      cnt_vld_q   <= cnt_vld_d;
      scan_cnt_q  <= scan_cnt_d;
      rd_vld_q    <= rd_vld_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    found_idx_q <= found_idx_d;
    tgt_q       <= tgt_d;
    rfault_q    <= rfault_d;
    raddr_q     <= raddr_d;
    res_kind_q  <= res_kind_d;
    res_paddr_q <= res_paddr_d;
    res_pidx_q  <= res_pidx_d;
    if (load_out) begin
      out_kind_q  <= res_kind_q;
      out_paddr_q <= res_paddr_q;
      out_pidx_q  <= res_pidx_q;
      out_mask_q  <= mask_q;
    end
  end

  assign frame_kind_o   = out_kind_q;
  assign poll_address_o = out_paddr_q;
  assign poll_index_o   = out_pidx_q;
  assign node_ok_mask_o = out_mask_q;

`ifndef SYNTHESIS
  // no health bit beyond the last node is ever set
  a_mask_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mask_q >> NODE_COUNT) == 16'd0)
    else $error("health bit set for a node that does not exist");

  // a poll result always names a real node
  a_poll_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_kind_q == bpnhm_pkg::KIND_POLL)) |-> ({1'b0, out_pidx_q} < NODES5))
    else $error("poll index out of range");

  // non-poll results carry zero address and slot
  a_nonpoll_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_kind_q != bpnhm_pkg::KIND_POLL))
      |-> ((out_paddr_q == 8'd0) && (out_pidx_q == 4'd0)))
    else $error("address or slot on a non-poll result");

  // slot counter stays within one past the broadcast slot
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= (NODES5 + 5'd1))
    else $error("slot counter out of range");

  // a count update follows its read and targets a real node
  a_cnt_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bpnhm_pkg::ST_CNT_MOD)
      |-> (($past(state_q) == bpnhm_pkg::ST_CNT_RD) && (5'(tgt_q) < NODES5)))
    else $error("fault count update without a read of a valid node");
`endif

endmodule

// File: tb/poll_health_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// poll_health_tb_pkg
// Event and frame types plus the scoreboard of the poll monitor testbench.
// The scoreboard mirrors the poll sequencer, the fault counters and the
// address table, and turns each accepted bus event into the frame it expects.
// ----------------------------------------------------------------------------
package poll_health_tb_pkg;

  import bpnhm_pkg::*;

  localparam int NODES       = 10;
  localparam int TABLE_SLOTS = 16;

  // func codes with no meaning on the bus
  localparam logic [2:0] FUNC_UNUSED_LO = 3'd6;
  localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] reply_fault;
    logic [7:0] reply_address;
    logic [3:0] entry_index;
    logic [7:0] entry_address;
  } bus_ev_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  poll_address;
    logic [3:0]  poll_index;
    logic [15:0] ok_mask;
  } frame_t;

  class health_scoreboard;
    logic [7:0]  fault_limit;
    logic [4:0]  slot_counter;
    logic        data_pending;
    logic [4:0]  last_polled;
    logic [7:0]  fault_count [TABLE_SLOTS];
    logic [15:0] ok_mask;
    logic [7:0]  addr_table [TABLE_SLOTS];
    frame_t      expected_frames [$];
    int unsigned failures;

    // state as it stands after reset
    function new();
      fault_limit  = FAULT_LIMIT_RESET;
      slot_counter = 5'(NODES);
      data_pending = 1'b0;
      last_polled  = 5'(NODES);
      ok_mask      = '0;
      failures     = 0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        fault_count[i] = '0;
        addr_table[i]  = '0;
      end
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction

    // one more fault against a node, saturating one past the limit
    function void count_fault(input logic [4:0] node);
      logic [7:0] cap;
      if (node >= NODES) return;
      cap = (fault_limit > FAULT_LIMIT_CAP) ? FAULT_LIMIT_CAP : fault_limit;
      if (fault_count[node] < cap) begin
        fault_count[node]++;
      end else if (fault_count[node] == cap) begin
        fault_count[node]++;
        ok_mask[node] = 1'b0;
      end
    endfunction

    // advance the mirror by one accepted event and queue its frame
    function void note_bus_event(input bus_ev_t ev);
      frame_t exp;
      int     hit;
      exp.kind         = KIND_NONE;
      exp.poll_address = '0;
      exp.poll_index   = '0;
      case (ev.func)
        FUNC_FRAME: begin
          if (slot_counter > NODES) slot_counter = '0;
          if (data_pending || slot_counter == NODES) begin
            // broadcast takes the slot, nobody is left to charge
            data_pending = 1'b0;
            exp.kind     = KIND_BCAST;
            last_polled  = 5'(NODES);
          end else begin
            exp.kind         = KIND_POLL;
            exp.poll_index   = slot_counter[3:0];
            exp.poll_address = addr_table[slot_counter[3:0]];
            last_polled      = slot_counter;
          end
          slot_counter = slot_counter + 5'd1;
        end
        FUNC_SILENCE: count_fault(last_polled);
        FUNC_REPLY: begin
          // last matching slot wins
          hit = NODES;
          for (int i = 0; i < NODES; i++) begin
            if (addr_table[i] == ev.reply_address) hit = i;
          end
          if (hit < NODES) begin
            if (ev.reply_fault == 8'd0) begin
              ok_mask[hit]     = 1'b1;
              fault_count[hit] = '0;
            end else begin
              count_fault(5'(hit));
            end
          end
        end
        FUNC_DATA: data_pending = 1'b1;
        FUNC_SESSION: begin
          ok_mask = '0;
          for (int i = 0; i < TABLE_SLOTS; i++) fault_count[i] = '0;
        end
        FUNC_LOAD: begin
          if (ev.entry_index < NODES) addr_table[ev.entry_index] = ev.entry_address;
        end
        default: ;
      endcase
      exp.ok_mask = ok_mask;
      expected_frames.push_back(exp);
    endfunction

    // compare a result transfer with the oldest expected frame
    function void check_frame(input frame_t got);
      frame_t exp;
      if (expected_frames.size() == 0) begin
        $error("result transfer with no frame expected: frame_kind %0d", got.kind);
        failures++;
        return;
      end
      exp = expected_frames.pop_front();
      if (got.kind !== exp.kind) begin
        $error("frame_kind: expected %0d, actual %0d", exp.kind, got.kind);
        failures++;
      end
      if (got.poll_address !== exp.poll_address) begin
        $error("poll_address: expected %0d, actual %0d", exp.poll_address, got.poll_address);
        failures++;
      end
      if (got.poll_index !== exp.poll_index) begin
        $error("poll_index: expected %0d, actual %0d", exp.poll_index, got.poll_index);
        failures++;
      end
      if (got.ok_mask !== exp.ok_mask) begin
        $error("node_ok_mask: expected %h, actual %h", exp.ok_mask, got.ok_mask);
        failures++;
      end
    endfunction
  endclass

endpackage

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the bus poll node health monitor.
// A directed opening loads the address table and walks through broadcasts,
// silences, replies and sessions; random phases under several fault limits
// then mix poll and reply sequences with noise, while both channels idle at
// random and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;

  import bpnhm_pkg::*;
  import poll_health_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 800000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES   = NODES + 8;
  localparam int unsigned PHASES          = 6;
  localparam int unsigned PHASE_ITEMS     = 200;
  localparam int unsigned LONG_BURST      = 258;
  localparam logic [2:0]  ADDR_FAULT_LIMIT = {CFG_IDX_FAULT_LIMIT, 2'b00};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  func_i = '0;
  logic [7:0]  reply_fault_i = '0;
  logic [7:0]  reply_address_i = '0;
  logic [3:0]  entry_index_i = '0;
  logic [7:0]  entry_address_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  frame_kind_o;
  logic [7:0]  poll_address_o;
  logic [3:0]  poll_index_o;
  logic [15:0] node_ok_mask_o;

  health_scoreboard sb;
  int unsigned      sent_count = 0;
  int unsigned      taken_count = 0;
  int unsigned      cycle_count = 0;
  bit               hold_off_req = 1'b0;

  bus_poll_node_health_monitor #(
    .NODE_COUNT (NODES)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .reply_fault_i   (reply_fault_i),
    .reply_address_i (reply_address_i),
    .entry_index_i   (entry_index_i),
    .entry_address_i (entry_address_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .frame_kind_o    (frame_kind_o),
    .poll_address_o  (poll_address_o),
    .poll_index_o    (poll_index_o),
    .node_ok_mask_o  (node_ok_mask_o)
  );

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // event with every field random
  function automatic bus_ev_t random_ev(input logic [2:0] f);
    bus_ev_t ev;
    ev.func          = f;
    ev.reply_fault   = 8'($urandom_range(255, 0));
    ev.reply_address = 8'($urandom_range(255, 0));
    ev.entry_index   = 4'($urandom_range(15, 0));
    ev.entry_address = 8'($urandom_range(255, 0));
    return ev;
  endfunction

  // one input transfer, entered and left at a falling edge
  task automatic send_ev(input bus_ev_t ev);
    int unsigned gap;
    gap = ((sent_count % 200) >= 160) ? 0 : $urandom_range(13, 0);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    func_i          <= ev.func;
    reply_fault_i   <= ev.reply_fault;
    reply_address_i <= ev.reply_address;
    entry_index_i   <= ev.entry_index;
    entry_address_i <= ev.entry_address;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_bus_event(ev);
    sent_count++;
    @(negedge clk_i);
  endtask

  task automatic send_fields(input logic [2:0] f, input logic [7:0] fault,
                             input logic [7:0] raddr, input logic [3:0] eidx,
                             input logic [7:0] eaddr);
    bus_ev_t ev;
    ev.func          = f;
    ev.reply_fault   = fault;
    ev.reply_address = raddr;
    ev.entry_index   = eidx;
    ev.entry_address = eaddr;
    send_ev(ev);
  endtask

  // stop offering and let every expected frame come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // setup and access phase, entered and left at a falling edge
  task automatic apb_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // new fault limit while the block is idle, then read it back
  task automatic settle_and_program(input logic [7:0] value);
    logic [31:0] rdata;
    drain_results();
    @(negedge clk_i);
    apb_access(1'b1, ADDR_FAULT_LIMIT, {24'd0, value}, rdata);
    @(negedge clk_i);
    apb_access(1'b0, ADDR_FAULT_LIMIT, 32'd0, rdata);
    if (rdata[7:0] !== value) begin
      $error("fault_limit read-back: expected %0d, actual %0d", value, rdata[7:0]);
      sb.failures++;
    end
    sb.fault_limit = value;
  endtask

  // one random sequence, mostly poll and reply with some noise
  task automatic random_sequence();
    bus_ev_t     ev;
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(99, 0);
    if (pick < 60) begin
      // poll then the polled node answers, faults or stays silent
      send_ev(random_ev(FUNC_FRAME));
      ev = random_ev(FUNC_REPLY);
      ev.reply_address = sb.addr_table[sb.last_polled[3:0]];
      n = $urandom_range(99, 0);
      if (n < 45) begin
        ev.reply_fault = 8'd0;
        send_ev(ev);
      end else if (n < 75) begin
        ev.reply_fault = 8'($urandom_range(255, 1));
        send_ev(ev);
      end else begin
        repeat ($urandom_range(3, 1)) send_ev(random_ev(FUNC_SILENCE));
      end
    end else if (pick < 68) begin
      send_ev(random_ev(FUNC_DATA));
      send_ev(random_ev(FUNC_FRAME));
    end else if (pick < 72) begin
      // reload a slot, often with an address already in use
      ev = random_ev(FUNC_LOAD);
      if ($urandom_range(1, 0) != 0) ev.entry_address = sb.addr_table[$urandom_range(NODES - 1, 0)];
      send_ev(ev);
    end else if (pick < 75) begin
      send_ev(random_ev(FUNC_SESSION));
    end else if (pick < 80) begin
      // reply from a random, most likely unknown, address
      send_ev(random_ev(FUNC_REPLY));
    end else if (pick < 90) begin
      // unsolicited reply from a known node
      ev = random_ev(FUNC_REPLY);
      ev.reply_address = sb.addr_table[$urandom_range(NODES - 1, 0)];
      if ($urandom_range(1, 0) != 0) ev.reply_fault = 8'd0;
      send_ev(ev);
    end else if (pick < 96) begin
      send_ev(random_ev(3'($urandom_range(7, 0))));
    end else begin
      // run of silences after a frame, up to the limit plus three and at most 40
      n = sb.fault_limit + 3;
      if (n > 40) n = 40;
      send_ev(random_ev(FUNC_FRAME));
      repeat ($urandom_range(n, 1)) send_ev(random_ev(FUNC_SILENCE));
    end
  endtask

  // result side with random stalls and one long hold-off
  initial begin : result_sink
    int unsigned stall;
    frame_t      got;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = HOLD_OFF_CYCLES;
      end else if ((taken_count % 170) >= 130) begin
        stall = 0;
      end else begin
        stall = $urandom_range(13, 0);
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      got.kind         = kind_e'(frame_kind_o);
      got.poll_address = poll_address_o;
      got.poll_index   = poll_index_o;
      got.ok_mask      = node_ok_mask_o;
      sb.check_frame(got);
      taken_count++;
      @(negedge clk_i);
    end
  end

  // stimulus
  initial begin : stimulus
    bus_ev_t     ev;
    logic [7:0]  seed_addr [NODES];
    logic [7:0]  limits [PHASES];
    int unsigned phase_start;
    sb = new();
    seed_addr = '{8'h00, 8'h13, 8'h22, 8'h35, 8'h4C, 8'h5A, 8'h6E, 8'h22, 8'hA1, 8'hFF};
    limits = '{8'd0, 8'd1, FAULT_LIMIT_CAP, 8'd3, FAULT_LIMIT_MAX, 8'd0};
    limits[PHASES - 1] = 8'($urandom_range(20, 0));
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // fill the table first, slot 7 shares its address with slot 2
    for (int i = 0; i < NODES; i++) begin
      send_fields(FUNC_LOAD, 8'h00, 8'hFF, 4'(i), seed_addr[i]);
    end
    // loads past the last node are dropped
    send_fields(FUNC_LOAD, 8'hFF, 8'h00, 4'd15, 8'h77);
    send_fields(FUNC_LOAD, 8'h00, 8'h00, 4'd10, 8'h88);
    // silence with no node polled yet
    send_fields(FUNC_SILENCE, 8'h00, 8'h00, 4'd0, 8'h00);
    // counter starts at the end, so the first frame is a broadcast
    send_fields(FUNC_FRAME, 8'hFF, 8'hFF, 4'd15, 8'hFF);
    send_fields(FUNC_SILENCE, 8'h00, 8'h00, 4'd0, 8'h00);
    // counter past the end restarts at slot 0
    send_fields(FUNC_FRAME, 8'h00, 8'h00, 4'd0, 8'h00);
    send_fields(FUNC_REPLY, 8'h00, 8'h00, 4'd0, 8'h00);
    send_fields(FUNC_FRAME, 8'h00, 8'h00, 4'd0, 8'h00);
    send_fields(FUNC_SILENCE, 8'h00, 8'h00, 4'd0, 8'h00);
    send_fields(FUNC_SILENCE, 8'h00, 8'h00, 4'd0, 8'h00);
    // duplicate address resolves to the higher slot
    send_fields(FUNC_REPLY, 8'h00, 8'h22, 4'd0, 8'h00);
    // pending data pre-empts the next poll
    send_fields(FUNC_DATA, 8'h00, 8'h00, 4'd0, 8'h00);
    send_fields(FUNC_FRAME, 8'h00, 8'h00, 4'd0, 8'h00);
    // unknown address is ignored
    send_fields(FUNC_REPLY, 8'hFF, 8'h99, 4'd0, 8'h00);
    send_fields(FUNC_REPLY, 8'hFF, 8'h13, 4'd0, 8'h00);
    send_fields(FUNC_REPLY, 8'h00, 8'hFF, 4'd0, 8'h00);
    send_fields(FUNC_UNUSED_LO, 8'hFF, 8'hFF, 4'd15, 8'hFF);
    send_fields(FUNC_UNUSED_HI, 8'hFF, 8'hFF, 4'd15, 8'hFF);
    send_fields(FUNC_SESSION, 8'h00, 8'h00, 4'd0, 8'h00);

    for (int p = 0; p < PHASES; p++) begin
      settle_and_program(limits[p]);
      if (p == 1) hold_off_req = 1'b1;
      if (limits[p] == FAULT_LIMIT_CAP) begin
        // mark one node healthy then keep it silent past the top limit
        do begin
          send_ev(random_ev(FUNC_FRAME));
        end while (sb.last_polled >= NODES);
        ev = random_ev(FUNC_REPLY);
        ev.reply_fault   = 8'd0;
        ev.reply_address = sb.addr_table[sb.last_polled[3:0]];
        send_ev(ev);
        repeat (LONG_BURST) send_ev(random_ev(FUNC_SILENCE));
      end
      phase_start = sent_count;
      while (sent_count - phase_start < PHASE_ITEMS) random_sequence();
    end

    drain_results();
    if (sb.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
